FILE: hdl/dpsrle_pkg.sv
package dpsrle_pkg;

  // Item and state widths
  localparam int CHANNELS      = 16;
  localparam int MAX_RUNS      = 1024;
  localparam int DURATION_BITS = 32;
  localparam int WORD_W        = 16;
  localparam int DUR_W         = DURATION_BITS;
  localparam int IDX_W         = 16;
  localparam int LEN_W         = 11;

  // Constants derived from the widths above
  localparam logic [WORD_W-1:0] CH_MASK   = WORD_W'((64'd1 << CHANNELS) - 64'd1);
  localparam logic [IDX_W-1:0]  COUNT_MAX = {IDX_W{1'b1}};
  localparam logic [DUR_W-1:0]  DUR_MAX   = {DUR_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1024);
  localparam logic [IDX_W-1:0]  RUNS_LIM  = IDX_W'(MAX_RUNS);

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One result item
  typedef struct packed {
    logic              port;
    logic [WORD_W-1:0] word;
    logic [DUR_W-1:0]  duration;
    logic [IDX_W-1:0]  index;
    logic              stored;
    logic              final_run;
    logic [IDX_W-1:0]  total;
  } res_t;

  // Up to two results written to the queue in the same cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: hdl/dpsrle_run_track.sv
module dpsrle_run_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_port_sel,
  input  logic [dpsrle_pkg::WORD_W-1:0] in_sample_word,
  input  logic                        in_last_sample,
  input  logic [dpsrle_pkg::LEN_W-1:0]  port_length,
  input  logic                        room,
  output dpsrle_pkg::push_t           push
);
  import dpsrle_pkg::*;

  // Input register
  logic              s1_vld_r;
  logic              s1_port_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_last_r;

  // Per-port run state
  logic [WORD_W-1:0] cur_word_r [2];
  logic [DUR_W-1:0]  run_len_r  [2];
  logic [IDX_W-1:0]  run_cnt_r  [2];
  logic              run_open_r [2];

  logic              take;
  logic              fire;
  logic              p;
  logic [WORD_W-1:0] w;
  logic              open;
  logic [WORD_W-1:0] cw;
  logic [DUR_W-1:0]  rl;
  logic [IDX_W-1:0]  rc;
  logic              change;
  logic [WORD_W-1:0] cw_nxt;
  logic [DUR_W-1:0]  rl_nxt;
  logic [IDX_W-1:0]  rc_nxt;
  logic [IDX_W-1:0]  lim;
  res_t              res_chg;
  res_t              res_fin;

  assign take     = in_valid && in_ready;
  assign fire     = s1_vld_r && room;
  assign in_ready = !s1_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (take) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_port_r <= in_port_sel;
      s1_word_r <= in_sample_word;
      s1_last_r <= in_last_sample;
    end
  end

  // Read the state of the item's port.
  assign p    = s1_port_r;
  assign w    = s1_word_r & CH_MASK;
  assign open = run_open_r[p];
  assign cw   = cur_word_r[p];
  assign rl   = run_len_r[p];
  assign rc   = run_cnt_r[p];

  // Open, close or extend the run.
  always_comb begin
    change = 1'b0;
    cw_nxt = cw;
    rl_nxt = rl;
    rc_nxt = rc;
    if (!open) begin
      cw_nxt = w;
      rl_nxt = DUR_W'(1);
      rc_nxt = '0;
    end else if (w != cw) begin
      change = 1'b1;
      cw_nxt = w;
      rl_nxt = DUR_W'(1);
      rc_nxt = (rc < COUNT_MAX) ? rc + IDX_W'(1) : rc;
    end else if (rl < DUR_MAX) begin
      rl_nxt = rl + DUR_W'(1);
    end
  end

  // Stored limit is the configured length clamped to the table size.
  assign lim = (IDX_W'(port_length) < RUNS_LIM) ? IDX_W'(port_length) : RUNS_LIM;

  // The run closed by a word change carries the old state.
  always_comb begin
    res_chg.port      = p;
    res_chg.word      = cw;
    res_chg.duration  = rl;
    res_chg.index     = rc;
    res_chg.stored    = rc < lim;
    res_chg.final_run = 1'b0;
    res_chg.total     = '0;
  end

  // The flushed final run carries the updated state and the run total.
  always_comb begin
    res_fin.port      = p;
    res_fin.word      = cw_nxt;
    res_fin.duration  = rl_nxt;
    res_fin.index     = rc_nxt;
    res_fin.stored    = rc_nxt < lim;
    res_fin.final_run = 1'b1;
    res_fin.total     = (rc_nxt < COUNT_MAX) ? rc_nxt + IDX_W'(1) : COUNT_MAX;
  end

  // A word change goes out first, then the flush.
  always_comb begin
    push.n  = 2'd0;
    push.r0 = res_fin;
    push.r1 = res_fin;
    if (fire) begin
      push.n = {1'b0, change} + {1'b0, s1_last_r};
      if (change) begin
        push.r0 = res_chg;
      end
    end
  end

  // Update the port's state; the last sample returns it to empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        cur_word_r[i] <= '0;
        run_len_r[i]  <= '0;
        run_cnt_r[i]  <= '0;
        run_open_r[i] <= 1'b0;
      end
    end else if (fire) begin
      if (s1_last_r) begin
        cur_word_r[p] <= '0;
        run_len_r[p]  <= '0;
        run_cnt_r[p]  <= '0;
        run_open_r[p] <= 1'b0;
      end else begin
        cur_word_r[p] <= cw_nxt;
        run_len_r[p]  <= rl_nxt;
        run_cnt_r[p]  <= rc_nxt;
        run_open_r[p] <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_last_r |=> !run_open_r[$past(p)])
    else $error("port still open after its last sample");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("results pushed without queue room");
  a_open_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_last_r |=> run_len_r[$past(p)] != '0)
    else $error("open run with zero duration");
`endif

endmodule

FILE: hdl/dpsrle_res_fifo.sv
module dpsrle_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  dpsrle_pkg::push_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output dpsrle_pkg::res_t  out_res
);
  import dpsrle_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  // Room for a full pair of results from the next item.
  assign room = count_r <= CNT_W'(FIFO_DEPTH - 2);

  // Entry storage: one or two writes per cycle.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r + CNT_W'(push.n) <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.n == 2'd0 |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("fill count wrong after pop");
`endif

endmodule

FILE: hdl/dual_port_state_run_length_encoder.sv
// Run-length encoder for two ports of 16-bit channel words. Each sample item
// goes into an input register, is compared with its port's open run, and
// leaves zero, one or two run items (a closed run, then the final flush when
// the sample is marked last) in a four-entry result queue. The queue drains
// one run item per cycle while out_ready is high, so a new sample is taken
// every cycle as long as each sample yields at most one run; a sample that
// yields two runs takes two slots of output bandwidth. A run item passes
// through the input register, then the result queue, before it is visible.
// The input register advances only while the queue has two free entries.
// port_length is written through cfg_we and cfg_wdata and resets to 1024.
module dual_port_state_run_length_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_port_sel,
  input  logic [dpsrle_pkg::WORD_W-1:0] in_sample_word,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_port,
  output logic [dpsrle_pkg::WORD_W-1:0] out_run_word,
  output logic [dpsrle_pkg::DUR_W-1:0]  out_run_duration,
  output logic [dpsrle_pkg::IDX_W-1:0]  out_run_index,
  output logic                          out_stored,
  output logic                          out_final_run,
  output logic [dpsrle_pkg::IDX_W-1:0]  out_total_runs,
  input  logic                          cfg_we,
  input  logic [dpsrle_pkg::LEN_W-1:0]  cfg_wdata
);
  import dpsrle_pkg::*;

  logic [LEN_W-1:0] port_length_r;
  logic             room;
  push_t            push;
  res_t             res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_length_r <= LEN_RESET;
    end else if (cfg_we) begin
      port_length_r <= cfg_wdata;
    end
  end

  dpsrle_run_track u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_port_sel    (in_port_sel),
    .in_sample_word (in_sample_word),
    .in_last_sample (in_last_sample),
    .port_length    (port_length_r),
    .room           (room),
    .push           (push)
  );

  dpsrle_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Result item fields.
  assign out_port         = res.port;
  assign out_run_word     = res.word;
  assign out_run_duration = res.duration;
  assign out_run_index    = res.index;
  assign out_stored       = res.stored;
  assign out_final_run    = res.final_run;
  assign out_total_runs   = res.total;

endmodule
